// File: rtl/core/pf_pkg.sv
// Package for the Playfair encryptor: opcodes, letter constants, controller states
// and the command and status structs between the controller and the datapath.
// No dependencies.
package pf_pkg;

  localparam int CELLS = 25;
  localparam int LETTERS = 26;
  localparam int LETTER_W = 5;
  localparam int CELL_W = 5;

  localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
  localparam logic [LETTER_W-1:0] LETTER_LAST = 5'd25;
  localparam logic [CELL_W-1:0] CELL_COUNT = 5'd25;
  localparam logic [LETTERS-1:0] SEEN_RESET = 26'd1 << LETTER_J;

  typedef enum logic [1:0] {
    OP_KEY_CHAR  = 2'd0,
    OP_KEY_END   = 2'd1,
    OP_TEXT_CHAR = 2'd2,
    OP_TEXT_END  = 2'd3
  } pf_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS_A,
    ST_POS_B,
    ST_CELL,
    ST_SQ_A,
    ST_EMIT_A,
    ST_SQ_B,
    ST_EMIT_B
  } pf_state_t;

  typedef struct packed {
    logic key_clear;
    logic key_place;
    logic fill_start;
    logic fill_step;
    logic fill_finish;
    logic pend_set;
    logic pend_clear;
    logic pair_load;
    logic pair_b_x;
    logic pos_sel_b;
    logic lat_p1;
    logic lat_cells;
    logic sq_sel_b;
    logic out_load;
    logic out_last;
  } pf_cmd_t;

  typedef struct packed {
    pf_op_t op;
    logic   letter_ok;
    logic   key_complete;
    logic   pending_valid;
    logic   pending_match;
    logic   fill_last;
    logic   out_free;
  } pf_stat_t;

endpackage

// File: rtl/core/pf_in_if.sv
// Input channel of the Playfair encryptor: valid, ready and one character item.
// No dependencies.
interface pf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_byte;

  modport source(output valid, output opcode, output char_byte, input ready);
  modport sink(input valid, input opcode, input char_byte, output ready);
endinterface

// File: rtl/core/pf_out_if.sv
// Output channel of the Playfair encryptor: valid, ready and one ciphertext letter.
// No dependencies.
interface pf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cipher_letter;
  logic       last_of_pair;

  modport source(output valid, output cipher_letter, output last_of_pair, input ready);
  modport sink(input valid, input cipher_letter, input last_of_pair, output ready);
endinterface

// File: rtl/core/pf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pf_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/pf_ctrl.sv
// Controller of the Playfair encryptor: sequences key loading, the key-end fill walk
// and the read steps of each pair. Depends on pf_pkg.
module pf_ctrl
  import pf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  pf_stat_t stat,
  output pf_cmd_t  cmd
);

  pf_state_t state, state_next;
  logic      accept;

  assign item_ready = (state == ST_IDLE);
  assign accept = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (stat.op)
            OP_KEY_END: begin
              if (!stat.key_complete) begin
                state_next = ST_FILL;
              end
            end
            OP_TEXT_CHAR: begin
              if (stat.key_complete && stat.letter_ok && stat.pending_valid) begin
                state_next = ST_POS_A;
              end
            end
            OP_TEXT_END: begin
              if (stat.key_complete && stat.pending_valid) begin
                state_next = ST_POS_A;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (stat.fill_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_POS_A: state_next = ST_POS_B;
      ST_POS_B: state_next = ST_CELL;
      ST_CELL: state_next = ST_SQ_A;
      ST_SQ_A: state_next = ST_EMIT_A;
      ST_EMIT_A: begin
        if (stat.out_free) begin
          state_next = ST_SQ_B;
        end
      end
      ST_SQ_B: state_next = ST_EMIT_B;
      ST_EMIT_B: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (stat.op)
            OP_KEY_CHAR: begin
              cmd.key_clear = stat.key_complete;
              cmd.key_place = stat.letter_ok;
            end
            OP_KEY_END: begin
              cmd.fill_start = !stat.key_complete;
            end
            OP_TEXT_CHAR: begin
              if (stat.key_complete && stat.letter_ok) begin
                if (!stat.pending_valid) begin
                  cmd.pend_set = 1'b1;
                end else if (stat.pending_match) begin
                  cmd.pair_load = 1'b1;
                  cmd.pair_b_x = 1'b1;
                end else begin
                  cmd.pair_load = 1'b1;
                  cmd.pend_clear = 1'b1;
                end
              end
            end
            OP_TEXT_END: begin
              if (stat.key_complete && stat.pending_valid) begin
                cmd.pair_load = 1'b1;
                cmd.pair_b_x = 1'b1;
                cmd.pend_clear = 1'b1;
              end
            end
            default: cmd = '0;
          endcase
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        cmd.fill_finish = stat.fill_last;
      end
      ST_POS_A: cmd.pos_sel_b = 1'b0;
      ST_POS_B: begin
        cmd.pos_sel_b = 1'b1;
        cmd.lat_p1 = 1'b1;
      end
      ST_CELL: begin
        cmd.pos_sel_b = 1'b1;
        cmd.lat_cells = 1'b1;
      end
      ST_SQ_A: cmd.sq_sel_b = 1'b0;
      ST_EMIT_A: cmd.out_load = stat.out_free;
      ST_SQ_B: cmd.sq_sel_b = 1'b1;
      ST_EMIT_B: begin
        cmd.sq_sel_b = 1'b1;
        cmd.out_load = stat.out_free;
        cmd.out_last = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded while the output register is full");

  a_pair_starts_lookup: assert property (@(posedge clk) disable iff (rst)
    cmd.pair_load |=> state == ST_POS_A)
    else $error("pair loaded without starting the lookup");

endmodule

// File: rtl/core/pf_datapath.sv
// Datapath of the Playfair encryptor: key state, the square and position RAMs,
// the pair lookup and the output register. Depends on pf_pkg and pf_ram.
module pf_datapath
  import pf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_byte,
  input  pf_cmd_t     cmd,
  output pf_stat_t    stat,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [6:0]  cipher_letter,
  output logic        last_of_pair
);

  logic [LETTERS-1:0]  seen_mask, seen_eff;
  logic [CELL_W-1:0]   fill_count, fill_eff;
  logic                key_complete;
  logic                pending_valid;
  logic [LETTER_W-1:0] pending_letter;
  logic [LETTER_W-1:0] fill_idx;
  logic [LETTER_W-1:0] pair_a, pair_b;
  logic [CELL_W-1:0]   p1, cell1, cell2;
  logic [LETTER_W-1:0] result_letter;

  logic                in_ok;
  logic [LETTER_W-1:0] in_letter;
  logic [LETTER_W-1:0] place_letter;
  logic                place_we;
  logic [CELL_W-1:0]   pos_rdata;
  logic [LETTER_W-1:0] sq_rdata;
  logic [CELL_W-1:0]   cell1_next, cell2_next;
  logic                out_free;

  function automatic logic [2:0] cell_row(input logic [CELL_W-1:0] c);
    logic [2:0] r;
    if (c >= 5'd20) begin
      r = 3'd4;
    end else if (c >= 5'd15) begin
      r = 3'd3;
    end else if (c >= 5'd10) begin
      r = 3'd2;
    end else if (c >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic logic [2:0] cell_col(input logic [CELL_W-1:0] c);
    logic [CELL_W-1:0] d;
    d = c - 5'(cell_row(c)) * 5'd5;
    return d[2:0];
  endfunction

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == 3'd4) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [CELL_W-1:0] make_cell(input logic [2:0] r, input logic [2:0] c);
    return 5'(r) * 5'd5 + 5'(c);
  endfunction

  always_comb begin
    in_ok = 1'b0;
    in_letter = '0;
    if (char_byte >= 8'd65 && char_byte <= 8'd90) begin
      in_ok = 1'b1;
      in_letter = 5'(char_byte - 8'd65);
    end else if (char_byte >= 8'd97 && char_byte <= 8'd122) begin
      in_ok = 1'b1;
      in_letter = 5'(char_byte - 8'd97);
    end
    if (in_letter == LETTER_J) begin
      in_letter = LETTER_I;
    end
  end

  assign seen_eff = cmd.key_clear ? SEEN_RESET : seen_mask;
  assign fill_eff = cmd.key_clear ? '0 : fill_count;
  assign place_letter = cmd.fill_step ? fill_idx : in_letter;
  assign place_we = (cmd.key_place || cmd.fill_step) && (fill_eff < CELL_COUNT)
                    && !seen_eff[place_letter];

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_mask <= SEEN_RESET;
      fill_count <= '0;
      key_complete <= 1'b0;
      pending_valid <= 1'b0;
      pending_letter <= '0;
    end else begin
      if (cmd.key_clear || place_we) begin
        seen_mask <= place_we ? (seen_eff | (26'd1 << place_letter)) : seen_eff;
        fill_count <= place_we ? fill_eff + 5'd1 : fill_eff;
      end
      if (cmd.key_clear) begin
        key_complete <= 1'b0;
      end else if (cmd.fill_finish) begin
        key_complete <= 1'b1;
      end
      if (cmd.pend_set) begin
        pending_valid <= 1'b1;
        pending_letter <= in_letter;
      end else if (cmd.pend_clear) begin
        pending_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_start) begin
      fill_idx <= '0;
    end else if (cmd.fill_step) begin
      fill_idx <= fill_idx + 5'd1;
    end
    if (cmd.pair_load) begin
      pair_a <= pending_letter;
      pair_b <= cmd.pair_b_x ? LETTER_X : in_letter;
    end
    if (cmd.lat_p1) begin
      p1 <= pos_rdata;
    end
    if (cmd.lat_cells) begin
      cell1 <= cell1_next;
      cell2 <= cell2_next;
    end
  end

  always_comb begin
    logic [2:0] r1, c1, r2, c2;
    r1 = cell_row(p1);
    c1 = cell_col(p1);
    r2 = cell_row(pos_rdata);
    c2 = cell_col(pos_rdata);
    if (r1 == r2) begin
      cell1_next = make_cell(r1, wrap_inc(c1));
      cell2_next = make_cell(r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      cell1_next = make_cell(wrap_inc(r1), c1);
      cell2_next = make_cell(wrap_inc(r2), c2);
    end else begin
      cell1_next = make_cell(r1, c2);
      cell2_next = make_cell(r2, c1);
    end
  end

  pf_ram #(.WIDTH(LETTER_W), .DEPTH(CELLS)) u_square (
    .clk   (clk),
    .we    (place_we),
    .waddr (fill_eff),
    .wdata (place_letter),
    .raddr (cmd.sq_sel_b ? cell2 : cell1),
    .rdata (sq_rdata)
  );

  pf_ram #(.WIDTH(CELL_W), .DEPTH(LETTERS)) u_position (
    .clk   (clk),
    .we    (place_we),
    .waddr (place_letter),
    .wdata (fill_eff),
    .raddr (cmd.pos_sel_b ? pair_b : pair_a),
    .rdata (pos_rdata)
  );

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_letter <= sq_rdata;
      last_of_pair <= cmd.out_last;
    end
  end

  assign cipher_letter = 7'd65 + 7'(result_letter);

  assign stat.op = pf_op_t'(opcode);
  assign stat.letter_ok = in_ok;
  assign stat.key_complete = key_complete;
  assign stat.pending_valid = pending_valid;
  assign stat.pending_match = (pending_letter == in_letter);
  assign stat.fill_last = (fill_idx == LETTER_LAST);
  assign stat.out_free = out_free;

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CELL_COUNT)
    else $error("fill count beyond the square");

  a_fill_completes: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_finish |=> (fill_count == CELL_COUNT) && key_complete)
    else $error("key-end fill left the square incomplete");

  a_no_write_after_key: assert property (@(posedge clk) disable iff (rst)
    place_we |-> (!key_complete || cmd.key_clear))
    else $error("square written while the key is complete");

endmodule

// File: rtl/core/playfair_encryptor.sv
// Top level of the Playfair encryptor: joins the controller and the datapath.
// Depends on pf_pkg, pf_in_if, pf_out_if, pf_ctrl and pf_datapath.
//
//   Channel  Role    Payload
//   item     sink    opcode (2), char_byte (8)
//   result   source  cipher_letter (7), last_of_pair (1)
//
// A key character, a pair's first letter or an ignored item keeps the controller idle.
// A key end on an incomplete key starts a fill walk over all 26 letters, one letter per
// cycle through the single write port of the square and position RAMs.
// A completed pair stalls while the output is full; the single read port of each RAM
// sets the two lookups and two square reads in sequence.
// Reset clears control, key and output state only; the square RAM is never read unwritten.
// The item channel is not ready while a fill walk or a pair is in progress.
module playfair_encryptor
  import pf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pf_in_if.sink      item,
  pf_out_if.source   result
);

  pf_cmd_t  cmd;
  pf_stat_t stat;

  pf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pf_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .opcode        (item.opcode),
    .char_byte     (item.char_byte),
    .cmd           (cmd),
    .stat          (stat),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .cipher_letter (result.cipher_letter),
    .last_of_pair  (result.last_of_pair)
  );

endmodule
